// File: sv/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types, character constants and lookup functions for the line escape
// encoder.
// ----------------------------------------------------------------------------
package rle_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	localparam logic [3:0] PFX_LAST = 4'd8;
	localparam logic [3:0] SFX_LAST = 4'd2;

	typedef enum logic [2:0] {
		CLS_PASS,
		CLS_SPACE,
		CLS_AMP,
		CLS_LT,
		CLS_GT,
		CLS_HEX
	} cls_t;

	typedef enum logic [1:0] {
		SEG_IDLE,
		SEG_PFX,
		SEG_BODY,
		SEG_SFX
	} seg_t;

	typedef struct packed {
		logic [7:0] data;
		cls_t       cls;
		logic       first;
		logic       last;
		logic       dir;
	} job_t;

	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		if (b inside {[8'h21:8'h25], [8'h27:8'h3B], 8'h3D, [8'h3F:8'h7E]}) begin
			c = CLS_PASS;
		end else begin
			case (b)
				CH_SPACE: c = CLS_SPACE;
				CH_AMP:   c = CLS_AMP;
				CH_LT:    c = CLS_LT;
				CH_GT:    c = CLS_GT;
				default:  c = CLS_HEX;
			endcase
		end
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) c = 8'h30 + {4'd0, n};
		else           c = 8'h37 + {4'd0, n};
		return c;
	endfunction

	// Index of the last character of the escaped byte.
	function automatic logic [2:0] body_last(input cls_t cls);
		logic [2:0] n;
		case (cls)
			CLS_PASS:  n = 3'd0;
			CLS_SPACE: n = 3'd5;
			CLS_AMP:   n = 3'd4;
			CLS_LT:    n = 3'd3;
			CLS_GT:    n = 3'd3;
			default:   n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] pfx_char(input logic dir, input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0, 4'd4: c = "&";
			4'd1, 4'd5: c = dir ? "l" : "g";
			4'd2, 4'd6: c = "t";
			4'd3, 4'd7: c = ";";
			default:    c = " ";
		endcase
		return c;
	endfunction

	function automatic logic [7:0] body_char(input job_t j, input logic [2:0] idx);
		logic [7:0] c;
		case (j.cls)
			CLS_PASS: c = j.data;
			CLS_SPACE: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "n";
					3'd2:    c = "b";
					3'd3:    c = "s";
					3'd4:    c = "p";
					default: c = ";";
				endcase
			end
			CLS_AMP: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "a";
					3'd2:    c = "m";
					3'd3:    c = "p";
					default: c = ";";
				endcase
			end
			CLS_LT, CLS_GT: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = (j.cls == CLS_LT) ? "l" : "g";
					3'd2:    c = "t";
					default: c = ";";
				endcase
			end
			default: begin
				case (idx)
					3'd0:    c = "%";
					3'd1:    c = hex_char(j.data[7:4]);
					default: c = hex_char(j.data[3:0]);
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [7:0] sfx_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = "%";
			2'd1:    c = "0";
			default: c = "A";
		endcase
		return c;
	endfunction

endpackage

// File: sv/raw_line_escape_encoder.sv
// ----------------------------------------------------------------------------
// raw_line_escape_encoder
// Escapes the bytes of a message line into display text: direction prefix,
// entity or percent escapes, and a line-end suffix, one character per result.
// ----------------------------------------------------------------------------
//  channel  | transfer when   | payload
//  ---------+-----------------+------------------------------------------------
//  input    | push  && !full  | data_byte, first_byte, last_byte, direction
//  result   | pop   && !empty | out_char, run_last, line_end
//
// The sequencer emits one character per cycle unless the result is stalled;
// a byte gives 1 to 18 characters (prefix 9, escaped byte 1 to 6, suffix 3).
// A byte passes the input stage register, the job queue, the sequencer and
// the output register; a four-entry job queue absorbs input bursts.
// Reset clears the queue, the sequencer and the output register; no sweep.
// A stalled result holds the sequencer; input is still taken until the queue
// and the input stage are full.
module raw_line_escape_encoder import rle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       direction,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       line_end
);

	logic f_valid;
	logic f_ready;
	job_t f_job;
	logic q_valid;
	logic q_pop;
	job_t q_job;

	rle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.direction  (direction),
		.job_valid  (f_valid),
		.job_ready  (f_ready),
		.job        (f_job)
	);

	rle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_job   (f_job),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_job   (q_job)
	);

	rle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_pop   (q_pop),
		.job_head  (q_job),
		.empty     (empty),
		.pop       (pop),
		.out_char  (out_char),
		.run_last  (run_last),
		.line_end  (line_end)
	);

endmodule

// File: sv/rle_front.sv
// ----------------------------------------------------------------------------
// rle_front
// Input stage: takes raw bytes, classifies them and holds one classified job
// for the job queue.
// ----------------------------------------------------------------------------
module rle_front import rle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       direction,
	output logic       job_valid,
	input  logic       job_ready,
	output job_t       job
);

	logic valid_s1;
	job_t job_s1;
	logic in_ready;
	logic accept;

	assign in_ready  = !valid_s1 || job_ready;
	assign full      = !in_ready;
	assign accept    = push && in_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.data  <= data_byte;
			job_s1.cls   <= classify(data_byte);
			job_s1.first <= first_byte;
			job_s1.last  <= last_byte;
			job_s1.dir   <= direction;
		end
	end

endmodule

// File: sv/rle_queue.sv
// ----------------------------------------------------------------------------
// rle_queue
// Short job queue between the classifier and the character sequencer.
// ----------------------------------------------------------------------------
module rle_queue import rle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_job,
	output logic rd_valid,
	input  logic rd_pop,
	output job_t rd_job
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = (count_q != QCNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)      count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

// File: sv/rle_back.sv
// ----------------------------------------------------------------------------
// rle_back
// Character sequencer: walks prefix, escaped byte and suffix of each job and
// puts out one character per cycle, unless stalled, through an output register.
// ----------------------------------------------------------------------------
module rle_back import rle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	output logic       job_pop,
	input  job_t       job_head,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       line_end
);

	seg_t       seg_q, seg_d;
	logic [3:0] idx_q, idx_d;
	job_t       job_q;
	logic       ovalid_q;
	logic [7:0] ochar_q;
	logic       orun_q;
	logic       oend_q;

	logic [7:0] cur_char;
	logic       seg_end;
	logic       emit;
	logic       done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_IDLE;
			idx_q <= '0;
		end else begin
			seg_q <= seg_d;
			idx_q <= idx_d;
		end
	end

	always_comb begin
		cur_char = 8'h00;
		seg_end  = 1'b0;
		case (seg_q)
			SEG_PFX: begin
				cur_char = pfx_char(job_q.dir, idx_q);
				seg_end  = (idx_q == PFX_LAST);
			end
			SEG_BODY: begin
				cur_char = body_char(job_q, idx_q[2:0]);
				seg_end  = (idx_q[2:0] == body_last(job_q.cls));
			end
			SEG_SFX: begin
				cur_char = sfx_char(idx_q[1:0]);
				seg_end  = (idx_q == SFX_LAST);
			end
			default: begin
				cur_char = 8'h00;
				seg_end  = 1'b0;
			end
		endcase

		emit = (seg_q != SEG_IDLE) && (!ovalid_q || pop);
		done = emit && seg_end
			&& ((seg_q == SEG_SFX) || ((seg_q == SEG_BODY) && !job_q.last));
		job_pop = job_valid && ((seg_q == SEG_IDLE) || done);

		seg_d = seg_q;
		idx_d = idx_q;
		if (emit) begin
			if (seg_end) begin
				idx_d = '0;
				case (seg_q)
					SEG_PFX:  seg_d = SEG_BODY;
					SEG_BODY: seg_d = job_q.last ? SEG_SFX : SEG_IDLE;
					default:  seg_d = SEG_IDLE;
				endcase
			end else begin
				idx_d = idx_q + 1'b1;
			end
		end
		// A new job starts in the same cycle the previous one finishes.
		if (job_pop) begin
			seg_d = job_head.first ? SEG_PFX : SEG_BODY;
			idx_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (pop) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job_head;
		if (emit) begin
			ochar_q <= cur_char;
			orun_q  <= done;
			oend_q  <= done && (seg_q == SEG_SFX);
		end
	end

	assign empty    = !ovalid_q;
	assign out_char = ochar_q;
	assign run_last = orun_q;
	assign line_end = oend_q;

endmodule

// File: tb/raw_line_escape_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_line_escape_encoder_test
// Self-checking bench for the line escape encoder. Each byte sent is expanded
// into its expected character stream on transfer, and every character popped
// is compared in order. Covers both prefixes, every escape class, missing
// marks, random lines, long output stalls and a drained pause.
// ----------------------------------------------------------------------------
module raw_line_escape_encoder_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 80;

	typedef struct {
		logic [7:0] ch;
		logic       run_last;
		logic       line_end;
	} text_char_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;
	logic       direction;
	logic       empty;
	logic       pop;
	logic [7:0] out_char;
	logic       run_last;
	logic       line_end;

	text_char_t expected_chars[$];
	int         error_count = 0;
	int         items_sent = 0;
	int         quiet_cycles = 0;
	int         hold_request = 0;
	bit         idle_enable = 1'b1;

	raw_line_escape_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.direction  (direction),
		.empty      (empty),
		.pop        (pop),
		.out_char   (out_char),
		.run_last   (run_last),
		.line_end   (line_end)
	);

	always #5 clk = ~clk;

	// Expands one accepted byte into the characters it should produce.
	task automatic escape_byte(input logic [7:0] b, input logic f, input logic l,
			input logic d);
		string      hex_digits;
		string      s;
		text_char_t c;
		text_char_t chars[$];
		int         i;
		hex_digits = "0123456789ABCDEF";
		s = "";
		if (f) s = d ? "&lt;&lt; " : "&gt;&gt; ";
		if ((b >= 8'h21 && b <= 8'h25) || (b >= 8'h27 && b <= 8'h3B) ||
				b == 8'h3D || (b >= 8'h3F && b <= 8'h7E)) begin
			s = {s, string'(b)};
		end else if (b == 8'h20) begin
			s = {s, "&nbsp;"};
		end else if (b == 8'h26) begin
			s = {s, "&amp;"};
		end else if (b == 8'h3C) begin
			s = {s, "&lt;"};
		end else if (b == 8'h3E) begin
			s = {s, "&gt;"};
		end else begin
			s = {s, "%", string'(hex_digits[b[7:4]]), string'(hex_digits[b[3:0]])};
		end
		if (l) s = {s, "%0A"};
		for (i = 0; i < s.len(); i++) begin
			c.ch = s[i];
			c.run_last = (i == s.len() - 1);
			c.line_end = l && (i == s.len() - 1);
			chars.push_back(c);
		end
		foreach (chars[k]) expected_chars.push_back(chars[k]);
	endtask

	// Offers one byte and holds it until the transfer happens.
	task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
			input logic d);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		data_byte  <= b;
		first_byte <= f;
		last_byte  <= l;
		direction  <= d;
		do @(posedge clk); while (full);
		escape_byte(b, f, l, d);
		items_sent++;
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: b = 8'h20;
			1: b = 8'h26;
			2: b = 8'h3C;
			3: b = 8'h3E;
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	// A well-formed line; direction on later bytes is random to show it is ignored.
	task automatic send_line(input int len, input logic d);
		int i;
		for (i = 0; i < len; i++) begin
			send_byte(pick_byte(), i == 0, i == len - 1,
				(i == 0) ? d : ($urandom_range(0, 1) != 0));
		end
	endtask

	// The last byte offered has already transferred, so the input is released first.
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	task automatic test_prefixes();
		send_byte("A", 1'b1, 1'b1, 1'b0);
		send_byte("z", 1'b1, 1'b1, 1'b1);
	endtask

	task automatic test_escape_classes();
		logic [7:0] bytes[16];
		int         i;
		bytes = '{8'h00, 8'h20, 8'h21, 8'h25, 8'h26, 8'h27, 8'h3B, 8'h3C,
			8'h3D, 8'h3E, 8'h3F, 8'h7E, 8'h7F, 8'h0A, 8'h80, 8'hFF};
		for (i = 0; i < 16; i++) begin
			send_byte(bytes[i], i == 0, i == 15, (i == 0) ? 1'b0 : i[0]);
		end
	endtask

	task automatic test_missing_marks();
		send_byte(8'hA5, 1'b0, 1'b0, 1'b1);
		send_byte(8'h20, 1'b0, 1'b0, 1'b0);
		send_byte(8'h5A, 1'b0, 1'b1, 1'b1);
	endtask

	task automatic test_random_lines(input int count);
		while (items_sent < count) begin
			if ($urandom_range(0, 6) == 0) begin
				send_byte(pick_byte(), $urandom_range(0, 1) != 0,
					$urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
			end else begin
				send_line($urandom_range(1, 8), $urandom_range(0, 1) != 0);
			end
		end
	endtask

	// The output side stops for a long stretch while bytes keep coming.
	task automatic test_output_stall();
		int i;
		hold_request = LONG_HOLD;
		for (i = 0; i < 4; i++) send_line(5, i[0]);
	endtask

	task automatic test_sender_pause();
		send_line(3, 1'b1);
		wait_drained();
		send_line(3, 1'b0);
	endtask

	task automatic test_steady_stream();
		idle_enable = 1'b0;
		while (items_sent < 160) send_line($urandom_range(1, 6), $urandom_range(0, 1) != 0);
	endtask

	// Output side: random stall bursts plus the long hold on request.
	initial begin
		int pop_stall;
		int pop_hold;
		pop_stall = 0;
		pop_hold = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				pop_hold = hold_request;
				hold_request = 0;
			end
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else if (pop_stall > 0) begin
				pop <= 1'b0;
				pop_stall--;
			end else if (idle_enable && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				pop_stall = $urandom_range(0, 2);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && pop && !empty) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none, got %h", $time, out_char);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.ch) begin
					$display("%0t: out_char expected %h, got %h", $time, want.ch, out_char);
					error_count++;
				end
				if (run_last !== want.run_last) begin
					$display("%0t: run_last expected %b, got %b", $time, want.run_last,
						run_last);
					error_count++;
				end
				if (line_end !== want.line_end) begin
					$display("%0t: line_end expected %b, got %b", $time, want.line_end,
						line_end);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("raw_line_escape_encoder regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		push       <= 1'b0;
		data_byte  <= 8'h00;
		first_byte <= 1'b0;
		last_byte  <= 1'b0;
		direction  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_prefixes();
		test_escape_classes();
		test_missing_marks();
		test_random_lines(110);
		test_output_stall();
		test_sender_pause();
		test_steady_stream();

		push <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_chars.size() == 0) begin
			$display("raw_line_escape_encoder regression: pass");
		end else begin
			$display("raw_line_escape_encoder regression: fail");
		end
		$finish;
	end

endmodule
